>>> rtl/e2cd_pkg.sv
`timescale 1ns / 1ps

package e2cd_pkg;

  // payload widths
  localparam int UTC_W    = 32;
  localparam int OFFSET_W = 17;
  localparam int YEAR_W   = 8;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int DOW_W    = 3;

  // divider sizing
  localparam int DIVISOR_W = 6;
  localparam int DAYS_W    = 16;

  localparam logic [DIVISOR_W-1:0] SECS_PER_MIN  = 6'd60;
  localparam logic [DIVISOR_W-1:0] HOURS_PER_DAY = 6'd24;

  // reciprocals: x / 60 = (x * RECIP_60) >> 37, (x / 8) / 3 = ((x >> 3) * RECIP_3) >> 33,
  // exact for every 32-bit x
  localparam logic [UTC_W-1:0] RECIP_60       = 32'h8888_8889;
  localparam int               RECIP_60_SHIFT = 37;
  localparam logic [UTC_W-1:0] RECIP_3        = 32'hAAAA_AAAB;
  localparam int               RECIP_3_SHIFT  = 33;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd28800;

  // 2000-01-01 was a Saturday; weekday index 0 is Monday
  localparam logic [DOW_W-1:0] BASE_WEEKDAY = 3'd5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // divisor select
  typedef enum logic {
    DIV_BY_60 = 1'b0,
    DIV_BY_24 = 1'b1
  } div_sel_t;

  // request to the divider
  typedef struct packed {
    logic             start;
    logic [UTC_W-1:0] dividend;
    div_sel_t         sel;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic                 done;
    logic [UTC_W-1:0]     quot;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  // gregorian leap rule for 2000 + yo
  function automatic logic leap_year(input logic [YEAR_W-1:0] yo);
    logic by4;
    by4 = (yo[1:0] == 2'b00);
    return by4 && (yo != 8'd100) && (yo != 8'd200);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    d = 5'd31;
    if (mon == MONTH_FEB) begin
      d = leap ? 5'd29 : 5'd28;
    end else if (mon inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      d = 5'd30;
    end
    return d;
  endfunction

  // weekday index plus a step of 0..6, modulo 7
  function automatic logic [DOW_W-1:0] add_mod7(input logic [DOW_W-1:0] a,
                                                input logic [DOW_W-1:0] b);
    logic [DOW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[DOW_W-1:0];
  endfunction

  // remainder modulo 7 of a day number below 31
  function automatic logic [DOW_W-1:0] mod7_small(input logic [DAY_W-1:0] v);
    logic [DAY_W-1:0] r;
    r = v;
    if (r >= 5'd28) begin
      r = r - 5'd28;
    end else if (r >= 5'd21) begin
      r = r - 5'd21;
    end else if (r >= 5'd14) begin
      r = r - 5'd14;
    end else if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    return r[DOW_W-1:0];
  endfunction

endpackage

>>> rtl/e2cd_in_if.sv
`timescale 1ns / 1ps

interface e2cd_in_if;
  logic                      valid;
  logic                      ready;
  logic [e2cd_pkg::UTC_W-1:0] utc_seconds;

  modport source (output valid, output utc_seconds, input ready);
  modport sink (input valid, input utc_seconds, output ready);
endinterface

>>> rtl/e2cd_out_if.sv
`timescale 1ns / 1ps

interface e2cd_out_if;
  logic                        valid;
  logic                        ready;
  logic [e2cd_pkg::YEAR_W-1:0]  year_since_base;
  logic [e2cd_pkg::MONTH_W-1:0] month_number;
  logic [e2cd_pkg::DAY_W-1:0]   day_of_month;
  logic [e2cd_pkg::HOUR_W-1:0]  hour_of_day;
  logic [e2cd_pkg::MIN_W-1:0]   minute_of_hour;
  logic [e2cd_pkg::SEC_W-1:0]   second_of_minute;
  logic [e2cd_pkg::DOW_W-1:0]   day_of_week;

  modport source (output valid, output year_since_base, output month_number,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output day_of_week, input ready);
  modport sink (input valid, input year_since_base, input month_number,
                input day_of_month, input hour_of_day, input minute_of_hour,
                input second_of_minute, input day_of_week, output ready);
endinterface

>>> rtl/e2cd_div.sv
`timescale 1ns / 1ps

// divider by 60 or 24 through a reciprocal multiply; the product, then the quotient and remainder, are registered
module e2cd_div (
  input  logic               clk,
  input  logic               rst,
  input  e2cd_pkg::div_req_t req,
  output e2cd_pkg::div_rsp_t rsp
);
  import e2cd_pkg::*;

  logic [UTC_W-1:0]     num;
  div_sel_t             sel;
  logic [2*UTC_W-1:0]   prod;
  logic                 pend;
  logic                 done;
  logic [UTC_W-1:0]     quot;
  logic [DIVISOR_W-1:0] rem;

  logic [UTC_W-1:0]       mul_a;
  logic [UTC_W-1:0]       mul_b;
  logic [UTC_W-1:0]       q;
  logic [DIVISOR_W-1:0]   divisor;
  logic [2*DIVISOR_W-1:0] back;

  // operand select: divide by 24 as divide by 8, then by 3
  always_comb begin
    if (req.sel == DIV_BY_24) begin
      mul_a = req.dividend >> 3;
      mul_b = RECIP_3;
    end else begin
      mul_a = req.dividend;
      mul_b = RECIP_60;
    end
  end

  // quotient from the high product bits; remainder below 64 is exact mod 64
  always_comb begin
    if (sel == DIV_BY_24) begin
      q       = UTC_W'(prod >> RECIP_3_SHIFT);
      divisor = HOURS_PER_DAY;
    end else begin
      q       = UTC_W'(prod >> RECIP_60_SHIFT);
      divisor = SECS_PER_MIN;
    end
    back = q[DIVISOR_W-1:0] * divisor;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= req.start;
      done <= pend;
    end
  end

  // product on a request, then quotient and remainder from the registered product
  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.dividend;
      sel  <= req.sel;
      prod <= mul_a * mul_b;
    end
    if (pend) begin
      quot <= q;
      rem  <= num[DIVISOR_W-1:0] - back[DIVISOR_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

>>> rtl/epoch_seconds_to_calendar_date_top.sv
`timescale 1ns / 1ps

// Converts a count of seconds since 2000-01-01 00:00:00 UTC, plus the zone
// offset register (wrapping modulo 2^32), into local year, month, day, hour,
// minute, second and weekday (1 Monday .. 7 Sunday). One conversion runs at
// a time and the input is not ready while it runs. Seconds, minutes and
// hours come off through one shared reciprocal-multiply divider (three
// stages), the day count is then walked one year per cycle and one month
// per cycle, and the date is loaded into the output register, after which
// the input is ready again. A finished date waits in the output register
// while the next count is taken; a date that is still waiting there when
// the next one finishes holds the block in its last step.
module epoch_seconds_to_calendar_date_top (
  input  logic                            clk,
  input  logic                            rst,
  e2cd_in_if.sink                         time_in,
  e2cd_out_if.source                      date_out,
  input  logic                            cfg_we,
  input  logic [e2cd_pkg::OFFSET_W-1:0]   cfg_wdata
);
  import e2cd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SEC   = 7'b0000010,
    S_MIN   = 7'b0000100,
    S_HOUR  = 7'b0001000,
    S_YEAR  = 7'b0010000,
    S_MONTH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [OFFSET_W-1:0] zone_offset;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SEC_W-1:0]   sec;
  logic [MIN_W-1:0]   min;
  logic [HOUR_W-1:0]  hour;
  logic [DAYS_W-1:0]  days;
  logic [YEAR_W-1:0]  yo;
  logic [MONTH_W-1:0] mon;
  logic [DOW_W-1:0]   wd;

  logic               out_valid;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic [HOUR_W-1:0]  out_hour;
  logic [MIN_W-1:0]   out_min;
  logic [SEC_W-1:0]   out_sec;
  logic [DOW_W-1:0]   out_dow;

  logic             in_beat;
  logic             out_beat;
  logic             out_free;
  logic [UTC_W-1:0] local_sum;
  logic             leap;
  logic [8:0]       year_len;
  logic [DAY_W-1:0] month_len;
  logic             year_stop;
  logic             month_stop;

  assign in_beat   = time_in.valid && time_in.ready;
  assign out_beat  = out_valid && date_out.ready;
  assign out_free  = !out_valid || date_out.ready;
  assign local_sum = time_in.utc_seconds + {{(UTC_W-OFFSET_W){1'b0}}, zone_offset};

  // calendar lengths for the walk
  always_comb begin
    leap       = leap_year(yo);
    year_len   = leap ? 9'd366 : 9'd365;
    month_len  = month_days(mon, leap);
    year_stop  = (days < {{(DAYS_W-9){1'b0}}, year_len});
    month_stop = (days < {{(DAYS_W-DAY_W){1'b0}}, month_len}) || (mon >= MONTH_DEC);
  end

  // zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      zone_offset <= cfg_wdata;
    end
  end

  // divider requests per stage
  always_comb begin
    div_req = '0;
    case (state)
      S_IDLE: begin
        div_req.start    = in_beat;
        div_req.dividend = local_sum;
        div_req.sel      = DIV_BY_60;
      end
      S_SEC: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quot;
        div_req.sel      = DIV_BY_60;
      end
      S_MIN: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quot;
        div_req.sel      = DIV_BY_24;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  e2cd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_beat) state_next = S_SEC;
      S_SEC:   if (div_rsp.done) state_next = S_MIN;
      S_MIN:   if (div_rsp.done) state_next = S_HOUR;
      S_HOUR:  if (div_rsp.done) state_next = S_YEAR;
      S_YEAR:  if (year_stop) state_next = S_MONTH;
      S_MONTH: if (month_stop) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // time of day, then year and month walk with a running weekday
  always_ff @(posedge clk) begin
    case (state)
      S_SEC: begin
        if (div_rsp.done) begin
          sec <= div_rsp.rem;
        end
      end
      S_MIN: begin
        if (div_rsp.done) begin
          min <= div_rsp.rem;
        end
      end
      S_HOUR: begin
        if (div_rsp.done) begin
          hour <= div_rsp.rem[HOUR_W-1:0];
          days <= div_rsp.quot[DAYS_W-1:0];
          yo   <= '0;
          wd   <= BASE_WEEKDAY;
        end
      end
      S_YEAR: begin
        if (year_stop) begin
          mon <= MONTH_JAN;
        end else begin
          days <= days - {{(DAYS_W-9){1'b0}}, year_len};
          yo   <= yo + 8'd1;
          wd   <= add_mod7(wd, leap ? 3'd2 : 3'd1);
        end
      end
      S_MONTH: begin
        if (!month_stop) begin
          days <= days - {{(DAYS_W-DAY_W){1'b0}}, month_len};
          mon  <= mon + 4'd1;
          wd   <= add_mod7(wd, 3'(month_len - 5'd28));
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_year  <= yo;
      out_month <= mon;
      out_day   <= days[DAY_W-1:0] + 5'd1;
      out_hour  <= hour;
      out_min   <= min;
      out_sec   <= sec;
      out_dow   <= add_mod7(wd, mod7_small(days[DAY_W-1:0])) + 3'd1;
    end
  end

  assign time_in.ready             = (state == S_IDLE);
  assign date_out.valid            = out_valid;
  assign date_out.year_since_base  = out_year;
  assign date_out.month_number     = out_month;
  assign date_out.day_of_month     = out_day;
  assign date_out.hour_of_day      = out_hour;
  assign date_out.minute_of_hour   = out_min;
  assign date_out.second_of_minute = out_sec;
  assign date_out.day_of_week      = out_dow;

endmodule

>>> rtl/e2cd_chk.sv
`timescale 1ns / 1ps

module e2cd_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [e2cd_pkg::YEAR_W-1:0]    year_since_base,
  input logic [e2cd_pkg::MONTH_W-1:0]   month_number,
  input logic [e2cd_pkg::DAY_W-1:0]     day_of_month,
  input logic [e2cd_pkg::HOUR_W-1:0]    hour_of_day,
  input logic [e2cd_pkg::MIN_W-1:0]     minute_of_hour,
  input logic [e2cd_pkg::SEC_W-1:0]     second_of_minute,
  input logic [e2cd_pkg::DOW_W-1:0]     day_of_week
);

  // a conversion in flight blocks the next count
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // a stalled result stays valid and its date fields stay put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year_since_base) &&
      $stable(month_number) && $stable(day_of_month) && $stable(day_of_week))
    else $error("stalled result changed");

  // every shown result has its fields in calendar range (day of month checked from below only)
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_number >= 4'd1 && month_number <= 4'd12 &&
      day_of_month >= 5'd1 && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 &&
      second_of_minute <= 6'd59 && day_of_week >= 3'd1 && year_since_base <= 8'd136)
    else $error("result out of calendar range");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind epoch_seconds_to_calendar_date_top e2cd_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (time_in.valid),
  .in_ready         (time_in.ready),
  .out_valid        (date_out.valid),
  .out_ready        (date_out.ready),
  .year_since_base  (date_out.year_since_base),
  .month_number     (date_out.month_number),
  .day_of_month     (date_out.day_of_month),
  .hour_of_day      (date_out.hour_of_day),
  .minute_of_hour   (date_out.minute_of_hour),
  .second_of_minute (date_out.second_of_minute),
  .day_of_week      (date_out.day_of_week)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import e2cd_pkg::*;

  localparam int                 HALF_PERIOD = 6;
  localparam int                 RESET_CYCLES = 7;
  localparam int                 IDLE_LIMIT = 8000;
  localparam int                 HOLD_CYCLES = 1000;
  localparam int                 SETTLE_CYCLES = 300;
  localparam int unsigned        BASE_YEAR = 2000;
  localparam logic [UTC_W-1:0]   DAY_SECS = 32'd86400;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX_ZONE = 17'd86399;
  localparam logic [OFFSET_W-1:0] OFFSET_ALL_ONES = 17'h1FFFF;
  localparam int unsigned        MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // calendar corners, applied with a zero zone offset
  localparam logic [UTC_W-1:0] CALENDAR_POINTS [15] = '{
    32'd0,
    32'd86399,
    32'd59 * DAY_SECS,                    // 2000-02-29
    32'd365 * DAY_SECS + 32'd86399,       // last second of 2000
    32'd366 * DAY_SECS,                   // 2001-01-01
    32'd424 * DAY_SECS,                   // 2001-02-28
    32'd425 * DAY_SECS,                   // 2001-03-01
    32'd36525 * DAY_SECS - 32'd1,         // last second of 2099
    32'd36583 * DAY_SECS,                 // 2100-02-28, century year not leap
    32'd36584 * DAY_SECS,                 // 2100-03-01
    32'd36889 * DAY_SECS,                 // 2100-12-31
    32'd38044 * DAY_SECS,                 // 2104-02-29
    32'hFFFF_FFFF,
    32'h5555_5555,
    32'hAAAA_AAAA
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [DOW_W-1:0]   weekday;
  } date_t;

  // predicts local dates and checks them in order
  class date_scoreboard;
    date_t pending_dates[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function date_t convert_epoch(logic [UTC_W-1:0] utc, logic [OFFSET_W-1:0] offset);
      logic [UTC_W-1:0] total;
      int unsigned      days, yr, mon, mlen, y, m, w;
      date_t            d;
      // offset add wraps at 32 bits
      total = utc + UTC_W'(offset);
      d.second = SEC_W'(total % 60);
      total = total / 60;
      d.minute = MIN_W'(total % 60);
      total = total / 60;
      d.hour = HOUR_W'(total % 24);
      days = total / 24;
      // whole years, then whole months
      yr = BASE_YEAR;
      while (days >= (is_leap(yr) ? 366 : 365)) begin
        days -= is_leap(yr) ? 366 : 365;
        yr++;
      end
      mon = 1;
      while (1) begin
        mlen = (mon == 2 && is_leap(yr)) ? 29 : MONTH_LEN[mon-1];
        if (days < mlen || mon >= 12) break;
        days -= mlen;
        mon++;
      end
      d.year = YEAR_W'(yr - BASE_YEAR);
      d.month = MONTH_W'(mon);
      d.day = DAY_W'(days + 1);
      // weekday, january and february count as months 13 and 14 of the prior year
      y = yr;
      m = mon;
      if (m <= 2) begin
        m += 12;
        y -= 1;
      end
      w = (days + 1 + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400 + 1) % 7;
      d.weekday = DOW_W'(w == 0 ? 7 : w);
      return d;
    endfunction

    function void note_time(logic [UTC_W-1:0] utc, logic [OFFSET_W-1:0] offset);
      pending_dates.push_back(convert_epoch(utc, offset));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_date(date_t got);
      date_t want;
      if (pending_dates.size() == 0) begin
        $display("%0t: date beat with none expected, actual %0d-%0d-%0d", $time,
                 got.year, got.month, got.day);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year_since_base", want.year, got.year);
      compare_field("month_number", want.month, got.month);
      compare_field("day_of_month", want.day, got.day);
      compare_field("hour_of_day", want.hour, got.hour);
      compare_field("minute_of_hour", want.minute, got.minute);
      compare_field("second_of_minute", want.second, got.second);
      compare_field("day_of_week", want.weekday, got.weekday);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [OFFSET_W-1:0] cfg_wdata;
  logic [OFFSET_W-1:0] zone_offset;
  bit                  steady;
  bit                  hold_req;
  int                  idle_cycles;
  date_scoreboard      sb = new();

  e2cd_in_if  time_in ();
  e2cd_out_if date_out ();

  epoch_seconds_to_calendar_date_top dut (
    .clk       (clk),
    .rst       (rst),
    .time_in   (time_in),
    .date_out  (date_out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever begin
      #HALF_PERIOD clk = ~clk;
    end
  end

  // date sink: random back-pressure, one long hold-off on request
  initial begin
    date_t got;
    date_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (date_out.valid && date_out.ready) begin
        got.year = date_out.year_since_base;
        got.month = date_out.month_number;
        got.day = date_out.day_of_month;
        got.hour = date_out.hour_of_day;
        got.minute = date_out.minute_of_hour;
        got.second = date_out.second_of_minute;
        got.weekday = date_out.day_of_week;
        sb.check_date(got);
      end
      if (hold_req) begin
        date_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        date_out.ready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((time_in.valid && time_in.ready) || (date_out.valid && date_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("epoch_seconds_to_calendar_date_top: mismatch");
    $finish;
  end

  // offer one count, with random gaps, until accepted
  task automatic send_time(input logic [UTC_W-1:0] utc);
    while (!steady && $urandom_range(99) < 15) begin
      time_in.valid <= 1'b0;
      @(posedge clk);
    end
    time_in.valid <= 1'b1;
    time_in.utc_seconds <= utc;
    @(posedge clk);
    while (!time_in.ready) @(posedge clk);
    sb.note_time(utc, zone_offset);
  endtask

  task automatic end_burst();
    time_in.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    zone_offset = value;
  endtask

  // mix of raw counts, counts near the wrap, local midnights and last seconds of local days, and early dates
  function automatic logic [UTC_W-1:0] pick_utc();
    logic [UTC_W-1:0] wall_secs;
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(200000);
      2: begin
        wall_secs = 32'($urandom_range(49709)) * DAY_SECS;
        if ($urandom_range(1)) begin
          wall_secs = wall_secs + DAY_SECS - 32'd1;
        end
        return wall_secs - UTC_W'(zone_offset);
      end
      default: return $urandom_range(800 * 86400);
    endcase
  endfunction

  task automatic run_random(input int count, input int steady_from, input int steady_to,
                            input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      steady = (i >= steady_from) && (i < steady_to);
      if (i == hold_at) begin
        hold_req = 1'b1;
      end
      if (i == pause_at) begin
        end_burst();
        wait_drained();
      end
      send_time(pick_utc());
    end
    steady = 1'b0;
    end_burst();
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    zone_offset = OFFSET_RESET;
    steady = 1'b0;
    hold_req = 1'b0;
    time_in.valid = 1'b0;
    time_in.utc_seconds = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset offset, sum wrapping around 2^32
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);
    send_time(32'hFFFF_FFFF - 32'd28799);
    send_time(32'hFFFF_FFFF - 32'd28800);
    send_time(32'h8000_0000);
    end_burst();

    // calendar corners in plain utc
    write_offset('0);
    foreach (CALENDAR_POINTS[i]) begin
      send_time(CALENDAR_POINTS[i]);
    end
    end_burst();

    // random phases over several offsets, including beyond one day
    write_offset(OFFSET_MAX_ZONE);
    run_random(150, -1, -1, -1, -1);
    write_offset(OFFSET_ALL_ONES);
    run_random(150, -1, -1, -1, -1);
    write_offset(OFFSET_W'($urandom_range(86399)));
    run_random(300, 100, 200, 250, 50);
    write_offset('0);
    run_random(150, -1, -1, -1, -1);
    write_offset(OFFSET_W'($urandom_range(86399)));
    run_random(150, -1, -1, -1, -1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("epoch_seconds_to_calendar_date_top: match");
    end else begin
      $display("epoch_seconds_to_calendar_date_top: mismatch");
    end
    $finish;
  end

endmodule
